### rtl/core/gmr_pkg.sv
// Package for the grouped-mean restriction block.
// Holds value widths, parameter defaults, action codes, sequencer states and store controls.
// No dependencies.
`default_nettype none
package gmr_pkg;

	localparam int VALUE_W = 32;
	localparam int SUM_W = VALUE_W + 7;
	localparam int CELL_PORT_W = 10;
	localparam int COMP_PORT_W = 2;
	localparam int ACTION_W = 2;

	localparam int DEF_NUM_COARSE = 1024;
	localparam int DEF_COMPONENTS = 4;
	localparam int DEF_MAX_FINE = 64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD = 2'd0,
		ACT_ADD  = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic rd;
		logic orig_we;
		logic sum_we;
		logic cnt_we;
	} store_ctl_t;

endpackage
`default_nettype wire

### rtl/core/grouped_mean_restriction.sv
// Grouped-mean restriction: averages fine samples onto coarse cells.
// Load and ignored requests complete on acceptance; add requests read the store, then write back.
// A read with zero count skips the divider; an averaged read
// passes through the one-bit-per-cycle divider.
// After reset a clearing pass over all NUM_COARSE*COMPONENTS entries zeroes sums,
// counts and marks; no request is accepted until it ends.
`default_nettype none
module grouped_mean_restriction #(
	parameter int NUM_COARSE = gmr_pkg::DEF_NUM_COARSE,
	parameter int COMPONENTS = gmr_pkg::DEF_COMPONENTS,
	parameter int MAX_FINE_PER_COARSE = gmr_pkg::DEF_MAX_FINE
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire logic [gmr_pkg::ACTION_W-1:0]         action,
	input  wire logic [gmr_pkg::CELL_PORT_W-1:0]      coarse_index,
	input  wire logic [gmr_pkg::COMP_PORT_W-1:0]      component,
	input  wire logic signed [gmr_pkg::VALUE_W-1:0]   sample_value,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output logic [gmr_pkg::CELL_PORT_W-1:0]           coarse_index_res,
	output logic [gmr_pkg::COMP_PORT_W-1:0]           component_res,
	output logic signed [gmr_pkg::VALUE_W-1:0]        result_value,
	output logic                                      was_averaged,
	output logic                                      count_overflow
);
	import gmr_pkg::*;

	localparam int ENTRIES = NUM_COARSE * COMPONENTS;
	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CELL_W = (NUM_COARSE > 1) ? $clog2(NUM_COARSE) : 1;
	localparam int CNT_W = $clog2(MAX_FINE_PER_COARSE + 1);

	state_t state_q, state_d;
	logic [SLOT_W-1:0] clr_q;

	logic [ACTION_W-1:0]    item_act_q;
	logic [CELL_PORT_W-1:0] item_idx_q;
	logic [COMP_PORT_W-1:0] item_comp_q;
	logic signed [VALUE_W-1:0] item_value_q;
	logic [SLOT_W-1:0]      item_slot_q;
	logic [CELL_W-1:0]      item_cell_q;
	logic                   avg_q;
	logic                   ovf_q;
	logic signed [VALUE_W-1:0] res_q;

	logic                   res_valid_q;
	logic [CELL_PORT_W-1:0] out_idx_q;
	logic [COMP_PORT_W-1:0] out_comp_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                   out_avg_q;
	logic                   out_ovf_q;

	logic [31:0]            idx_ext;
	logic [31:0]            slot_ext;
	logic                   in_range;
	logic [SLOT_W-1:0]      in_slot;
	logic [CELL_W-1:0]      in_cell;

	store_ctl_t             ctl;
	logic [SLOT_W-1:0]      wr_slot;
	logic [CELL_W-1:0]      wr_cell;
	logic signed [SUM_W-1:0] sum_wdata;
	logic [CNT_W-1:0]       cnt_wdata;
	logic                   ovf_wdata;
	logic signed [VALUE_W-1:0] orig_rdata;
	logic signed [SUM_W-1:0] sum_rdata;
	logic [CNT_W-1:0]       cnt_rdata;
	logic                   ovf_rdata;

	logic                   capture;
	logic                   div_start;
	logic                   div_done;
	logic signed [VALUE_W-1:0] div_quot;
	logic                   out_load;

	always_comb begin
		idx_ext = 32'(coarse_index);
		slot_ext = idx_ext * 32'(COMPONENTS) + 32'(component);
		in_range = (idx_ext < 32'(NUM_COARSE)) && (32'(component) < 32'(COMPONENTS));
		in_slot = slot_ext[SLOT_W-1:0];
		in_cell = idx_ext[CELL_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		wr_slot = item_slot_q;
		wr_cell = item_cell_q;
		sum_wdata = '0;
		cnt_wdata = '0;
		ovf_wdata = 1'b0;
		capture = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.sum_we = 1'b1;
				ctl.cnt_we = 32'(clr_q) < 32'(NUM_COARSE);
				wr_slot = clr_q;
				wr_cell = clr_q[CELL_W-1:0];
				if (clr_q == SLOT_W'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid && in_range) begin
					capture = 1'b1;
					case (action)
						ACT_LOAD: begin
							ctl.orig_we = 1'b1;
							ctl.sum_we = 1'b1;
							ctl.cnt_we = (component == '0);
							wr_slot = in_slot;
							wr_cell = in_cell;
						end
						ACT_ADD, ACT_READ: begin
							ctl.rd = 1'b1;
							state_d = ST_EXEC;
						end
						default: ;
					endcase
				end
			end
			ST_EXEC: begin
				if (item_act_q == ACT_ADD) begin
					state_d = ST_IDLE;
					sum_wdata = sum_rdata + SUM_W'(item_value_q);
					if (item_comp_q == '0) begin
						ctl.cnt_we = 1'b1;
						if (32'(cnt_rdata) >= 32'(MAX_FINE_PER_COARSE)) begin
							cnt_wdata = cnt_rdata;
							ovf_wdata = 1'b1;
						end else begin
							cnt_wdata = cnt_rdata + CNT_W'(1);
							ovf_wdata = ovf_rdata;
							ctl.sum_we = 1'b1;
						end
					end else begin
						ctl.sum_we = !ovf_rdata;
					end
				end else if (cnt_rdata != '0) begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			item_act_q <= action;
			item_idx_q <= coarse_index;
			item_comp_q <= component;
			item_value_q <= sample_value;
			item_slot_q <= in_slot;
			item_cell_q <= in_cell;
		end
		if (state_q == ST_EXEC) begin
			avg_q <= cnt_rdata != '0;
			ovf_q <= ovf_rdata;
			res_q <= orig_rdata;
		end
		if (state_q == ST_DIV && div_done) begin
			res_q <= div_quot;
		end
		if (out_load) begin
			out_idx_q <= item_idx_q;
			out_comp_q <= item_comp_q;
			out_value_q <= res_q;
			out_avg_q <= avg_q;
			out_ovf_q <= ovf_q;
		end
	end

	gmr_store #(
		.NUM_COARSE(NUM_COARSE),
		.COMPONENTS(COMPONENTS),
		.CNT_W(CNT_W),
		.SLOT_W(SLOT_W),
		.CELL_W(CELL_W)
	) u_store (
		.clk(clk),
		.ctl(ctl),
		.rd_slot(in_slot),
		.rd_cell(in_cell),
		.wr_slot(wr_slot),
		.wr_cell(wr_cell),
		.orig_wdata(sample_value),
		.sum_wdata(sum_wdata),
		.cnt_wdata(cnt_wdata),
		.ovf_wdata(ovf_wdata),
		.orig_rdata(orig_rdata),
		.sum_rdata(sum_rdata),
		.cnt_rdata(cnt_rdata),
		.ovf_rdata(ovf_rdata)
	);

	gmr_divider #(
		.CNT_W(CNT_W)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(sum_rdata),
		.divisor(cnt_rdata),
		.done(div_done),
		.quotient(div_quot)
	);

	assign req_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;
	assign coarse_index_res = out_idx_q;
	assign component_res = out_comp_q;
	assign result_value = out_value_q;
	assign was_averaged = out_avg_q;
	assign count_overflow = out_ovf_q;

endmodule
`default_nettype wire

### rtl/core/gmr_store.sv
// Cell storage: original values, running sums, fine counts and overflow marks.
// Single write port and single registered read port per memory.
// Depends on gmr_pkg.
`default_nettype none
module gmr_store #(
	parameter int NUM_COARSE = 1024,
	parameter int COMPONENTS = 4,
	parameter int CNT_W = 7,
	parameter int SLOT_W = 12,
	parameter int CELL_W = 10
) (
	input  wire logic                               clk,
	input  wire gmr_pkg::store_ctl_t                ctl,
	input  wire logic [SLOT_W-1:0]                  rd_slot,
	input  wire logic [CELL_W-1:0]                  rd_cell,
	input  wire logic [SLOT_W-1:0]                  wr_slot,
	input  wire logic [CELL_W-1:0]                  wr_cell,
	input  wire logic signed [gmr_pkg::VALUE_W-1:0] orig_wdata,
	input  wire logic signed [gmr_pkg::SUM_W-1:0]   sum_wdata,
	input  wire logic [CNT_W-1:0]                   cnt_wdata,
	input  wire logic                               ovf_wdata,
	output logic signed [gmr_pkg::VALUE_W-1:0]      orig_rdata,
	output logic signed [gmr_pkg::SUM_W-1:0]        sum_rdata,
	output logic [CNT_W-1:0]                        cnt_rdata,
	output logic                                    ovf_rdata
);
	import gmr_pkg::*;

	localparam int ENTRIES = NUM_COARSE * COMPONENTS;

	logic signed [VALUE_W-1:0] orig_mem [ENTRIES];
	logic signed [SUM_W-1:0]   sum_mem  [ENTRIES];
	logic [CNT_W:0]            cnt_mem  [NUM_COARSE];

	always_ff @(posedge clk) begin
		if (ctl.orig_we) begin
			orig_mem[wr_slot] <= orig_wdata;
		end
		if (ctl.sum_we) begin
			sum_mem[wr_slot] <= sum_wdata;
		end
		if (ctl.cnt_we) begin
			cnt_mem[wr_cell] <= {ovf_wdata, cnt_wdata};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			orig_rdata <= orig_mem[rd_slot];
			sum_rdata <= sum_mem[rd_slot];
			{ovf_rdata, cnt_rdata} <= cnt_mem[rd_cell];
		end
	end

endmodule
`default_nettype wire

### rtl/core/gmr_divider.sv
// Iterative restoring divider: signed sum over unsigned count, one quotient bit a cycle.
// Truncates toward zero and saturates the quotient to the value range.
// Depends on gmr_pkg.
`default_nettype none
module gmr_divider #(
	parameter int CNT_W = 7
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [gmr_pkg::SUM_W-1:0]   dividend,
	input  wire logic [CNT_W-1:0]                   divisor,
	output logic                                    done,
	output logic signed [gmr_pkg::VALUE_W-1:0]      quotient
);
	import gmr_pkg::*;

	localparam int ITER_W = $clog2(SUM_W + 1);
	localparam logic [SUM_W-1:0] POS_LIM = {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] NEG_LIM = POS_LIM + SUM_W'(1);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;

	logic [SUM_W-1:0]  dv_u;
	logic [SUM_W-1:0]  mag;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    diff;
	logic              ge;
	logic [SUM_W-1:0]  quo_neg;
	logic [VALUE_W-1:0] sat;

	always_comb begin
		dv_u = dividend;
		mag = dv_u[SUM_W-1] ? (~dv_u + SUM_W'(1)) : dv_u;
		rem_sh = {rem_q, quo_q[SUM_W-1]};
		diff = rem_sh - {1'b0, den_q};
		ge = rem_sh >= {1'b0, den_q};
		quo_neg = ~quo_q + SUM_W'(1);
		if (neg_q) begin
			sat = (quo_q > NEG_LIM) ? {1'b1, {(VALUE_W-1){1'b0}}} : quo_neg[VALUE_W-1:0];
		end else begin
			sat = (quo_q > POS_LIM) ? {1'b0, {(VALUE_W-1){1'b1}}} : quo_q[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(SUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dv_u[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end else if (fin_q) begin
			quotient <= sat;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

### bench/tb_grouped_mean_restriction.sv
// Testbench for grouped_mean_restriction: directed table, then random load/add/read traffic.
// Results are checked in order against the table's expected values for directed reads, else against an in-bench model.
// Depends on gmr_pkg and the grouped_mean_restriction RTL.
`timescale 1ns / 100ps
module tb_grouped_mean_restriction;
	import gmr_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
	localparam int ENTRIES = DEF_NUM_COARSE * DEF_COMPONENTS;

	typedef struct packed {
		logic [CELL_PORT_W-1:0] coarse;
		logic [COMP_PORT_W-1:0] comp;
		logic [VALUE_W-1:0]     value;
		logic                   averaged;
		logic                   overflow;
	} mean_res_t;

	typedef struct packed {
		logic [ACTION_W-1:0]    act;
		logic [CELL_PORT_W-1:0] coarse;
		logic [COMP_PORT_W-1:0] comp;
		logic [VALUE_W-1:0]     val;
		logic [7:0]             reps;
		logic                   typed;
		mean_res_t              want;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic [ACTION_W-1:0]           action;
	logic [CELL_PORT_W-1:0]        coarse_index;
	logic [COMP_PORT_W-1:0]        component;
	logic signed [VALUE_W-1:0]     sample_value;
	logic                          res_valid;
	logic                          res_stall;
	logic [CELL_PORT_W-1:0]        coarse_index_res;
	logic [COMP_PORT_W-1:0]        component_res;
	logic signed [VALUE_W-1:0]     result_value;
	logic                          was_averaged;
	logic                          count_overflow;

	logic [VALUE_W-1:0]            orig_store [0:ENTRIES-1];
	bit                            orig_loaded [0:ENTRIES-1];
	logic signed [SUM_W-1:0]       sum_store [0:ENTRIES-1];
	int unsigned                   fine_cnt [0:DEF_NUM_COARSE-1];
	bit                            drop_mark [0:DEF_NUM_COARSE-1];

	mean_res_t                     pending_means [$];
	plan_row_t                     plan [$];
	int                            errors = 0;
	int                            req_count = 0;
	bit                            tx_burst = 1'b0;
	bit                            rx_burst = 1'b0;

	grouped_mean_restriction u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.coarse_index(coarse_index),
		.component(component),
		.sample_value(sample_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.coarse_index_res(coarse_index_res),
		.component_res(component_res),
		.result_value(result_value),
		.was_averaged(was_averaged),
		.count_overflow(count_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic bit predict_mean(input logic [ACTION_W-1:0] act,
			input logic [CELL_PORT_W-1:0] cidx, input logic [COMP_PORT_W-1:0] comp,
			input logic [VALUE_W-1:0] val, output mean_res_t res);
		int slot;
		int unsigned n;
		longint s;
		longint q;
		slot = int'(cidx) * DEF_COMPONENTS + int'(comp);
		res = '0;
		case (act)
			ACT_LOAD: begin
				orig_store[slot] = val;
				orig_loaded[slot] = 1'b1;
				sum_store[slot] = '0;
				if (comp == 0) begin
					fine_cnt[cidx] = 0;
					drop_mark[cidx] = 1'b0;
				end
				return 1'b0;
			end
			ACT_ADD: begin
				if (comp == 0) begin
					if (fine_cnt[cidx] >= DEF_MAX_FINE) begin
						drop_mark[cidx] = 1'b1;
						return 1'b0;
					end
					fine_cnt[cidx]++;
				end else if (drop_mark[cidx]) begin
					return 1'b0;
				end
				sum_store[slot] = sum_store[slot] + {{(SUM_W-VALUE_W){val[VALUE_W-1]}}, val};
				return 1'b0;
			end
			ACT_READ: begin
				n = fine_cnt[cidx];
				if (n > 0) begin
					s = sum_store[slot];
					q = s / longint'(n);
					if (q > 64'sh7fff_ffff)
						q = 64'sh7fff_ffff;
					if (q < -64'sh8000_0000)
						q = -64'sh8000_0000;
					res.value = q[VALUE_W-1:0];
				end else begin
					res.value = orig_store[slot];
				end
				res.coarse = cidx;
				res.comp = comp;
				res.averaged = (n > 0);
				res.overflow = drop_mark[cidx];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit read_defined(input int cidx, input int comp);
		return fine_cnt[cidx] != 0 || orig_loaded[cidx * DEF_COMPONENTS + comp];
	endfunction

	function automatic logic [VALUE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h3_ffff);
			3: return 32'h0 - $urandom_range(0, 32'h3_ffff);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(input logic [ACTION_W-1:0] act, input int cidx, input int comp,
			input logic [VALUE_W-1:0] val, input int reps, input bit typed,
			input logic [VALUE_W-1:0] wval, input bit wavg, input bit wovf);
		plan_row_t r;
		r.act = act;
		r.coarse = CELL_PORT_W'(cidx);
		r.comp = COMP_PORT_W'(comp);
		r.val = val;
		r.reps = 8'(reps);
		r.typed = typed;
		r.want = '{coarse: CELL_PORT_W'(cidx), comp: COMP_PORT_W'(comp), value: wval,
			averaged: wavg, overflow: wovf};
		plan.push_back(r);
	endtask

	task automatic issue(input logic [ACTION_W-1:0] act, input int cidx,
			input int comp, input logic [VALUE_W-1:0] val,
			input bit typed, input mean_res_t want);
		int gap;
		mean_res_t calc;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		action <= act;
		coarse_index <= CELL_PORT_W'(cidx);
		component <= COMP_PORT_W'(comp);
		sample_value <= val;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (predict_mean(act, CELL_PORT_W'(cidx), COMP_PORT_W'(comp), val, calc))
			pending_means.push_back(typed ? want : calc);
		if (act != ACT_NONE)
			req_count++;
	endtask

	initial begin : result_taker
		int hold;
		res_stall = 1'b0;
		forever begin
			if ($urandom_range(0, 24) == 0)
				rx_burst = !rx_burst;
			hold = rx_burst ? 0 : $urandom_range(0, 19);
			while (hold > 0) begin
				@(negedge clk);
				if (res_valid === 1'b1) begin
					res_stall <= 1'b1;
					hold--;
				end else begin
					res_stall <= 1'b0;
				end
			end
			@(negedge clk);
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid === 1'b1 && res_stall === 1'b0));
		end
	end

	always @(posedge clk) begin : result_check
		mean_res_t want;
		mean_res_t got;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			got = '{coarse: coarse_index_res, comp: component_res, value: result_value,
				averaged: was_averaged, overflow: count_overflow};
			if (pending_means.size() == 0) begin
				$display("%0t: result with none pending: cell %0d comp %0d value %h avg %b ovf %b",
					$time, got.coarse, got.comp, got.value, got.averaged, got.overflow);
				errors++;
			end else begin
				want = pending_means.pop_front();
				if (got !== want) begin
					$display("%0t: expected cell %0d comp %0d value %h avg %b ovf %b",
						$time, want.coarse, want.comp, want.value, want.averaged, want.overflow);
					$display("%0t:      got cell %0d comp %0d value %h avg %b ovf %b",
						$time, got.coarse, got.comp, got.value, got.averaged, got.overflow);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		mean_res_t no_want;
		logic [ACTION_W-1:0] act;
		int cidx;
		int c;
		int n;
		int kind;
		int base;
		int last_cell;
		int heavy_runs;
		bit neg;
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_LOAD;
		coarse_index = '0;
		component = '0;
		sample_value = '0;
		no_want = '0;
		last_cell = 0;
		heavy_runs = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			orig_store[i] = '0;
			orig_loaded[i] = 1'b0;
			sum_store[i] = '0;
		end
		for (int i = 0; i < DEF_NUM_COARSE; i++) begin
			fine_cnt[i] = 0;
			drop_mark[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(ACT_LOAD, 0, 0, 32'h8000_0000, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 0, 0, 0, 1, 1, 32'h8000_0000, 0, 0);
		add_row(ACT_LOAD, 1023, 3, 32'h7fff_ffff, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 1023, 3, 0, 1, 1, 32'h7fff_ffff, 0, 0);
		add_row(ACT_LOAD, 1023, 0, 32'h0001_0000, 1, 0, 0, 0, 0);
		add_row(ACT_ADD, 1023, 0, 32'hffff_0000, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 1023, 0, 0, 1, 1, 32'hffff_0000, 1, 0);
		add_row(ACT_READ, 1023, 3, 0, 1, 1, 32'h0000_0000, 1, 0);
		add_row(ACT_ADD, 1023, 3, 32'h7fff_ffff, 3, 0, 0, 0, 0);
		add_row(ACT_READ, 1023, 3, 0, 1, 1, 32'h7fff_ffff, 1, 0);
		add_row(ACT_ADD, 1023, 2, 32'h8000_0000, 2, 0, 0, 0, 0);
		add_row(ACT_READ, 1023, 2, 0, 1, 1, 32'h8000_0000, 1, 0);
		add_row(ACT_LOAD, 5, 0, 32'h0000_0000, 1, 0, 0, 0, 0);
		add_row(ACT_ADD, 5, 0, 32'hffff_fffd, 1, 0, 0, 0, 0);
		add_row(ACT_ADD, 5, 0, 32'h0000_0000, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 5, 0, 0, 1, 1, 32'hffff_ffff, 1, 0);
		add_row(ACT_LOAD, 682, 1, 32'ha5a5_a5a5, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 682, 1, 0, 1, 1, 32'ha5a5_a5a5, 0, 0);
		add_row(ACT_LOAD, 7, 0, 32'h0000_0000, 1, 0, 0, 0, 0);
		add_row(ACT_ADD, 7, 0, 32'h0002_0000, DEF_MAX_FINE + 1, 0, 0, 0, 0);
		add_row(ACT_ADD, 7, 1, 32'h0000_1234, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 7, 0, 0, 1, 1, 32'h0002_0000, 1, 1);
		add_row(ACT_READ, 7, 1, 0, 1, 1, 32'h0000_0000, 1, 1);
		add_row(ACT_NONE, 7, 0, 32'h0000_0000, 1, 0, 0, 0, 0);
		add_row(ACT_LOAD, 7, 0, 32'h0005_0000, 1, 0, 0, 0, 0);
		add_row(ACT_READ, 7, 0, 0, 1, 1, 32'h0005_0000, 0, 0);

		foreach (plan[i])
			repeat (plan[i].reps)
				issue(plan[i].act, int'(plan[i].coarse), int'(plan[i].comp), plan[i].val,
					plan[i].typed, plan[i].want);

		base = req_count;
		while (req_count - base < 300) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 11);
			if (kind == 11 && heavy_runs < 2) begin
				// drive one component's sum past its wrap point
				heavy_runs++;
				cidx = $urandom_range(0, DEF_NUM_COARSE - 1);
				c = $urandom_range(1, DEF_COMPONENTS - 1);
				neg = 1'($urandom_range(0, 1));
				issue(ACT_LOAD, cidx, 0, pick_sample(), 0, no_want);
				issue(ACT_LOAD, cidx, c, pick_sample(), 0, no_want);
				issue(ACT_ADD, cidx, 0, pick_sample(), 0, no_want);
				n = $urandom_range(140, 170);
				repeat (n)
					issue(ACT_ADD, cidx, c, (neg ? 32'h8000_0000 : 32'h7fff_0000)
						| ($urandom & 32'hffff), 0, no_want);
				issue(ACT_READ, cidx, c, pick_sample(), 0, no_want);
				issue(ACT_READ, cidx, 0, pick_sample(), 0, no_want);
			end else if (kind >= 8) begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					act = ACTION_W'($urandom_range(0, 3));
					cidx = $urandom_range(0, 1) ? last_cell : $urandom_range(0, DEF_NUM_COARSE - 1);
					c = $urandom_range(0, DEF_COMPONENTS - 1);
					if (act == ACT_READ && !read_defined(cidx, c))
						act = ACT_LOAD;
					issue(act, cidx, c, pick_sample(), 0, no_want);
				end
			end else begin
				cidx = $urandom_range(0, DEF_NUM_COARSE - 1);
				last_cell = cidx;
				issue(ACT_LOAD, cidx, 0, pick_sample(), 0, no_want);
				for (c = 1; c < DEF_COMPONENTS; c++)
					if ($urandom_range(0, 1))
						issue(ACT_LOAD, cidx, c, pick_sample(), 0, no_want);
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
				repeat (n) begin
					issue(ACT_ADD, cidx, 0, pick_sample(), 0, no_want);
					for (c = 1; c < DEF_COMPONENTS; c++)
						if ($urandom_range(0, 3) == 0)
							issue(ACT_ADD, cidx, c, pick_sample(), 0, no_want);
				end
				for (c = 0; c < DEF_COMPONENTS; c++)
					if (read_defined(cidx, c) && $urandom_range(0, 3) != 0)
						issue(ACT_READ, cidx, c, pick_sample(), 0, no_want);
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
rtl/core/gmr_pkg.sv
rtl/core/gmr_store.sv
rtl/core/gmr_divider.sv
rtl/core/grouped_mean_restriction.sv
bench/tb_grouped_mean_restriction.sv
